>>> hdl/pfc_pkg.sv
package pfc_pkg;

  // number of colour channels carried through the converter
  localparam int unsigned NUM_CHAN = 4;

  // channel slots
  localparam logic [1:0] CH_R = 2'd0;
  localparam logic [1:0] CH_G = 2'd1;
  localparam logic [1:0] CH_B = 2'd2;
  localparam logic [1:0] CH_A = 2'd3;

  // widths of the configuration port
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned FMT_W     = 4;

  // data widths
  localparam int unsigned WORD_W = 32;
  localparam int unsigned CHAN_W = 8;

  // pixel layout codes
  typedef enum logic [FMT_W-1:0] {
    FMT_RGB    = 4'd0,
    FMT_BGR    = 4'd1,
    FMT_RGBA   = 4'd2,
    FMT_BGRA   = 4'd3,
    FMT_ABGR   = 4'd4,
    FMT_ARGB   = 4'd5,
    FMT_RGB565 = 4'd6,
    FMT_BGR565 = 4'd7,
    FMT_L      = 4'd8,
    FMT_LA     = 4'd9
  } pixel_fmt_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_FORMAT = 1'b0,
    CFG_TARGET_FORMAT = 1'b1
  } cfg_reg_e;

  // position and precision loss of one channel within a packed word
  typedef struct packed {
    logic [4:0] shift;
    logic [3:0] loss;
  } chan_layout_t;

  typedef chan_layout_t [NUM_CHAN-1:0] fmt_layout_t;

  // build a full layout from per-channel shift and loss
  function automatic fmt_layout_t mk_layout(
    input logic [4:0] r_shift, input logic [3:0] r_loss,
    input logic [4:0] g_shift, input logic [3:0] g_loss,
    input logic [4:0] b_shift, input logic [3:0] b_loss,
    input logic [4:0] a_shift, input logic [3:0] a_loss
  );
    fmt_layout_t lay;
    lay[CH_R].shift = r_shift;
    lay[CH_R].loss  = r_loss;
    lay[CH_G].shift = g_shift;
    lay[CH_G].loss  = g_loss;
    lay[CH_B].shift = b_shift;
    lay[CH_B].loss  = b_loss;
    lay[CH_A].shift = a_shift;
    lay[CH_A].loss  = a_loss;
    return lay;
  endfunction

  // layout table; a loss of 8 means the channel is absent (empty mask),
  // and undefined codes behave as a layout with no channels at all
  function automatic fmt_layout_t fmt_layout(input logic [FMT_W-1:0] fmt);
    fmt_layout_t lay;
    unique case (fmt)
      FMT_RGB:    lay = mk_layout(5'd16, 4'd0, 5'd8,  4'd0, 5'd0,  4'd0, 5'd0,  4'd8);
      FMT_BGR:    lay = mk_layout(5'd0,  4'd0, 5'd8,  4'd0, 5'd16, 4'd0, 5'd0,  4'd8);
      FMT_RGBA:   lay = mk_layout(5'd24, 4'd0, 5'd16, 4'd0, 5'd8,  4'd0, 5'd0,  4'd0);
      FMT_BGRA:   lay = mk_layout(5'd8,  4'd0, 5'd16, 4'd0, 5'd24, 4'd0, 5'd0,  4'd0);
      FMT_ABGR:   lay = mk_layout(5'd0,  4'd0, 5'd8,  4'd0, 5'd16, 4'd0, 5'd24, 4'd0);
      FMT_ARGB:   lay = mk_layout(5'd16, 4'd0, 5'd8,  4'd0, 5'd0,  4'd0, 5'd24, 4'd0);
      FMT_RGB565: lay = mk_layout(5'd11, 4'd3, 5'd5,  4'd2, 5'd0,  4'd3, 5'd0,  4'd8);
      FMT_BGR565: lay = mk_layout(5'd0,  4'd3, 5'd5,  4'd2, 5'd11, 4'd3, 5'd0,  4'd8);
      FMT_L:      lay = mk_layout(5'd0,  4'd0, 5'd0,  4'd0, 5'd0,  4'd0, 5'd0,  4'd8);
      FMT_LA:     lay = mk_layout(5'd0,  4'd0, 5'd0,  4'd0, 5'd0,  4'd0, 5'd8,  4'd0);
      default:    lay = mk_layout(5'd0,  4'd8, 5'd0,  4'd8, 5'd0,  4'd8, 5'd0,  4'd8);
    endcase
    return lay;
  endfunction

endpackage

>>> hdl/pixel_format_converter.sv
// Packed pixel format converter.
// Input channel: pixel_word_i with in_valid_i / in_ready_o; one request is
// one packed source pixel (little-endian, unused upper bytes ignored).
// Output channel: converted_word_o with out_valid_o / out_ready_i; one result
// per request, in order, bytes beyond the target format size are zero.
// Config channel: cfg_valid_i / cfg_ready_o with cfg_index_i (0 source
// format, 1 target format) and cfg_data_i; always ready. Write only while
// no request is in flight.
// Pipeline: an accepted request is captured in the input register, and its
// conversion is then loaded into the result register that drives the output.
// Throughput: one pixel per cycle while the receiver does not stall; the
// limit is the single result register feeding the output channel.
// Reset: both formats return to RGBA and the pipeline is emptied.
// Receiver stall: the result register holds its word, the input register
// fills, and in_ready_o drops once both stages are occupied.
module pixel_format_converter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pfc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pfc_pkg::FMT_W-1:0]      cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [pfc_pkg::WORD_W-1:0]     pixel_word_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [pfc_pkg::WORD_W-1:0]     converted_word_o
);
  import pfc_pkg::*;

  logic [FMT_W-1:0]  src_fmt_q, src_fmt_d;
  logic [FMT_W-1:0]  dst_fmt_q, dst_fmt_d;
  logic              s1_valid_q, s1_valid_d;
  logic [WORD_W-1:0] s1_word_q;
  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] out_word_q;
  logic [WORD_W-1:0] conv_word;
  logic              in_fire;
  logic              out_load;
  logic              cfg_fire;

  // format registers
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;

  always_comb begin
    src_fmt_d = src_fmt_q;
    dst_fmt_d = dst_fmt_q;
    if (cfg_fire) begin
      unique case (cfg_index_i)
        CFG_SOURCE_FORMAT: src_fmt_d = cfg_data_i;
        CFG_TARGET_FORMAT: dst_fmt_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake control
  assign out_load   = ~out_valid_q | out_ready_i;
  assign in_ready_o = ~s1_valid_q | out_load;
  assign in_fire    = in_valid_i & in_ready_o;

  assign s1_valid_d  = in_fire | (s1_valid_q & ~out_load);
  assign out_valid_d = out_load ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_fmt_q   <= FMT_RGBA;
      dst_fmt_q   <= FMT_RGBA;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      src_fmt_q   <= src_fmt_d;
      dst_fmt_q   <= dst_fmt_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // conversion datapath
  pfc_convert u_convert (
    .src_fmt_i        (src_fmt_q),
    .dst_fmt_i        (dst_fmt_q),
    .pixel_word_i     (s1_word_q),
    .converted_word_o (conv_word)
  );

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_word_q <= pixel_word_i;
    end
    if (out_load && s1_valid_q) begin
      out_word_q <= conv_word;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign converted_word_o = out_word_q;

endmodule

>>> hdl/pfc_convert.sv
module pfc_convert (
  input  logic [pfc_pkg::FMT_W-1:0]  src_fmt_i,
  input  logic [pfc_pkg::FMT_W-1:0]  dst_fmt_i,
  input  logic [pfc_pkg::WORD_W-1:0] pixel_word_i,
  output logic [pfc_pkg::WORD_W-1:0] converted_word_o
);
  import pfc_pkg::*;

  fmt_layout_t src_lay;
  fmt_layout_t dst_lay;

  assign src_lay = fmt_layout(src_fmt_i);
  assign dst_lay = fmt_layout(dst_fmt_i);

  // unpack each channel to 8 bits, then repack into the target layout
  always_comb begin
    logic [CHAN_W-1:0] field;
    logic [CHAN_W-1:0] keep;
    logic [CHAN_W-1:0] chan_val;
    logic [CHAN_W-1:0] narrow;
    logic [WORD_W-1:0] acc;
    acc = '0;
    for (int unsigned c = 0; c < NUM_CHAN; c++) begin
      // extract: low bits zero filled, no replication
      field    = CHAN_W'(pixel_word_i >> src_lay[c].shift);
      keep     = 8'hff >> src_lay[c].loss;
      chan_val = (field & keep) << src_lay[c].loss;
      // pack: drop the low bits the target cannot hold
      narrow   = chan_val >> dst_lay[c].loss;
      acc      = acc | ({{(WORD_W-CHAN_W){1'b0}}, narrow} << dst_lay[c].shift);
    end
    converted_word_o = acc;
  end

endmodule
